// ----- src/slfd_pkg.sv -----
// shared types and constants for the sync/length frame deframer
package slfd_pkg;

    localparam int FIELD_COUNT = 4;
    localparam int SEP_W = $clog2(FIELD_COUNT + 1);
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    localparam logic [1:0] REG_SYNC_FIRST = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_FIELD_SEP = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST = 8'hEE;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hFE;
    localparam logic [7:0] FIELD_SEP_RST = 8'h24;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] field_separator;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             data_valid;
        logic [IDX_W-1:0] field_index;
        logic             last_of_frame;
        logic [31:0]      msg_type;
        logic             frame_status;
    } result_t;

endpackage

// ----- src/slfd_parser.sv -----
// frame parser: sync hunt, header capture and body tagging
module slfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  slfd_pkg::cfg_t    cfg,
    output logic              res_valid,
    output slfd_pkg::result_t res
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_LEN = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    logic [2:0]                   phase_reg, phase_next;
    logic [1:0]                   hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]                  type_reg, type_next;
    logic [31:0]                  remain_reg, remain_next;
    logic [slfd_pkg::SEP_W-1:0]   sep_cnt_reg, sep_cnt_next;

    always_comb
    begin
        logic is_sep;
        logic is_last;
        logic [slfd_pkg::SEP_W-1:0] sep_after;

        phase_next = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        type_next = type_reg;
        remain_next = remain_reg;
        sep_cnt_next = sep_cnt_reg;
        res_valid = 1'b0;
        res = '0;
        res.msg_type = type_reg;

        is_sep = (rx_byte == cfg.field_separator);
        is_last = (remain_reg == 32'd1);
        sep_after = sep_cnt_reg;
        if (is_sep && (sep_cnt_reg < slfd_pkg::SEP_W'(slfd_pkg::FIELD_COUNT)))
        begin
            sep_after = sep_cnt_reg + 1'b1;
        end

        case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    phase_next = PH_TYPE;
                    hdr_cnt_next = '0;
                end
                else if (rx_byte != cfg.sync_first)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TYPE:
            begin
                type_next = {type_reg[23:0], rx_byte};
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                if (hdr_cnt_reg == 2'd3)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                remain_next = {remain_reg[23:0], rx_byte};
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                if (hdr_cnt_reg == 2'd3)
                begin
                    sep_cnt_next = '0;
                    if ({remain_reg[23:0], rx_byte} == 32'd0)
                    begin
                        // empty body ends the frame at once
                        phase_next = PH_HUNT;
                        res_valid = 1'b1;
                        res.last_of_frame = 1'b1;
                        res.frame_status = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                res_valid = 1'b1;
                res.data_byte = rx_byte;
                res.data_valid = !is_sep;
                if (sep_cnt_reg > slfd_pkg::SEP_W'(slfd_pkg::IDX_MAX))
                begin
                    res.field_index = slfd_pkg::IDX_MAX;
                end
                else
                begin
                    res.field_index = slfd_pkg::IDX_W'(sep_cnt_reg);
                end
                res.last_of_frame = is_last;
                res.frame_status = is_last &&
                    (sep_after != slfd_pkg::SEP_W'(slfd_pkg::FIELD_COUNT - 1));
                sep_cnt_next = sep_after;
                remain_next = remain_reg - 32'd1;
                if (is_last)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC1 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            hdr_cnt_reg <= '0;
            type_reg <= '0;
            remain_reg <= '0;
            sep_cnt_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            type_reg <= type_next;
            remain_reg <= remain_next;
            sep_cnt_reg <= sep_cnt_next;
        end
    end

endmodule

// ----- src/sync_length_frame_deframer_unit.sv -----
// top level of the sync/length frame deframer
// a result is registered into the output register, or the skid register on a stall
// throughput: one byte per cycle while in_ready is high; parser updates once per byte
// an output register plus a skid register let one input transfer continue under an
// output stall; the input is then held off until the skid register drains
// reset: asynchronous, active low; hunts for sync; config registers take defaults
module sync_length_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic [1:0]  field_index,
    output logic        last_of_frame,
    output logic [31:0] msg_type,
    output logic        frame_status
);

    slfd_pkg::cfg_t    cfg_reg;
    slfd_pkg::result_t res;
    slfd_pkg::result_t out_reg, out_next;
    slfd_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              res_valid;
    logic              accept;
    logic              push;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first <= slfd_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second <= slfd_pkg::SYNC_SECOND_RST;
            cfg_reg.field_separator <= slfd_pkg::FIELD_SEP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                slfd_pkg::REG_SYNC_FIRST:  cfg_reg.sync_first <= cfg_data;
                slfd_pkg::REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data;
                slfd_pkg::REG_FIELD_SEP:   cfg_reg.field_separator <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_ready = !skid_valid_reg;
    assign accept = in_valid && in_ready;
    assign push = accept && res_valid;
    assign pop = out_valid_reg && out_ready;

    slfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register with skid stage
    always_comb
    begin
        out_next = out_reg;
        skid_next = skid_reg;
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            out_valid_next = skid_valid_reg || push;
            out_next = skid_valid_reg ? skid_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_next = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign data_byte = out_reg.data_byte;
    assign data_valid = out_reg.data_valid;
    assign field_index = out_reg.field_index;
    assign last_of_frame = out_reg.last_of_frame;
    assign msg_type = out_reg.msg_type;
    assign frame_status = out_reg.frame_status;

endmodule

// ----- sim/sync_length_frame_deframer_unit_test.sv -----
// testbench for the sync/length frame deframer: framed byte streams, predicted results, checks
module sync_length_frame_deframer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_AFTER = 150;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned OPENING_LEN = 28;
    localparam logic [8*OPENING_LEN-1:0] OPENING = {
        slfd_pkg::SYNC_FIRST_RST, 8'h00, slfd_pkg::SYNC_FIRST_RST, slfd_pkg::SYNC_FIRST_RST,
        slfd_pkg::SYNC_SECOND_RST,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
        slfd_pkg::SYNC_FIRST_RST, slfd_pkg::SYNC_SECOND_RST, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h05,
        8'h80, slfd_pkg::FIELD_SEP_RST, slfd_pkg::SYNC_FIRST_RST, slfd_pkg::FIELD_SEP_RST,
        slfd_pkg::FIELD_SEP_RST
    };

    localparam logic [2:0] HUNT_FIRST = 3'd0;
    localparam logic [2:0] AWAIT_SECOND = 3'd1;
    localparam logic [2:0] TAKE_TYPE = 3'd2;
    localparam logic [2:0] TAKE_LENGTH = 3'd3;
    localparam logic [2:0] PASS_BODY = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = slfd_pkg::REG_SYNC_FIRST;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [1:0]  field_index;
    logic        last_of_frame;
    logic [31:0] msg_type;
    logic        frame_status;

    // deframer state as predicted
    slfd_pkg::cfg_t             model_cfg = '{slfd_pkg::SYNC_FIRST_RST,
                                              slfd_pkg::SYNC_SECOND_RST,
                                              slfd_pkg::FIELD_SEP_RST};
    logic [2:0]                 parse_phase = HUNT_FIRST;
    logic [1:0]                 hdr_count = '0;
    logic [31:0]                type_acc = '0;
    logic [31:0]                length_acc = '0;
    logic [31:0]                body_left = '0;
    logic [slfd_pkg::SEP_W-1:0] sep_seen = '0;

    logic [7:0]         pending_bytes [$];
    slfd_pkg::result_t  expected_results [$];
    int unsigned stim_count = 0;
    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;

    sync_length_frame_deframer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .field_index   (field_index),
        .last_of_frame (last_of_frame),
        .msg_type      (msg_type),
        .frame_status  (frame_status)
    );

    always #4ns clk = ~clk;

    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return 0;
        end
        else if (pick < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        slfd_pkg::result_t r;
        r = '0;
        case (parse_phase)
            AWAIT_SECOND:
            begin
                if (b == model_cfg.sync_second)
                begin
                    parse_phase = TAKE_TYPE;
                    hdr_count = '0;
                    type_acc = '0;
                end
                else if (b != model_cfg.sync_first)
                begin
                    parse_phase = HUNT_FIRST;
                end
            end
            TAKE_TYPE:
            begin
                type_acc = {type_acc[23:0], b};
                if (hdr_count == 2'd3)
                begin
                    hdr_count = '0;
                    length_acc = '0;
                    parse_phase = TAKE_LENGTH;
                end
                else
                begin
                    hdr_count = hdr_count + 2'd1;
                end
            end
            TAKE_LENGTH:
            begin
                length_acc = {length_acc[23:0], b};
                if (hdr_count != 2'd3)
                begin
                    hdr_count = hdr_count + 2'd1;
                end
                else
                begin
                    hdr_count = '0;
                    sep_seen = '0;
                    if (length_acc == 32'd0)
                    begin
                        parse_phase = HUNT_FIRST;
                        r.last_of_frame = 1'b1;
                        r.msg_type = type_acc;
                        r.frame_status = 1'b1;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        body_left = length_acc;
                        parse_phase = PASS_BODY;
                    end
                end
            end
            PASS_BODY:
            begin
                r.field_index = (sep_seen > slfd_pkg::IDX_MAX) ? slfd_pkg::IDX_MAX :
                                sep_seen[slfd_pkg::IDX_W-1:0];
                r.data_byte = b;
                if (b == model_cfg.field_separator)
                begin
                    r.data_valid = 1'b0;
                    if (sep_seen < slfd_pkg::FIELD_COUNT)
                    begin
                        sep_seen = sep_seen + 1'b1;
                    end
                end
                else
                begin
                    r.data_valid = 1'b1;
                end
                body_left = body_left - 32'd1;
                r.last_of_frame = (body_left == 32'd0);
                r.msg_type = type_acc;
                r.frame_status = r.last_of_frame && (sep_seen != slfd_pkg::FIELD_COUNT - 1);
                if (r.last_of_frame)
                begin
                    parse_phase = HUNT_FIRST;
                end
                expected_results.push_back(r);
            end
            default:
            begin
                parse_phase = (b == model_cfg.sync_first) ? AWAIT_SECOND : HUNT_FIRST;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    function automatic void push_item(logic [7:0] b);
        pending_bytes.push_back(b);
        stim_count++;
    endfunction

    // mostly well-formed frames with random content, plus broken sync and line noise
    function automatic void fill_random(int unsigned target);
        logic [31:0] frame_type;
        logic [31:0] frame_len;
        logic [7:0]  body [];
        logic [7:0]  b;
        int unsigned sep_target;
        int unsigned pick;
        logic [7:0]  sf;
        logic [7:0]  ss;
        logic [7:0]  sep;
        sf = model_cfg.sync_first;
        ss = model_cfg.sync_second;
        sep = model_cfg.field_separator;
        stim_count = 0;
        while (stim_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                pick = $urandom_range(0, 99);
                frame_type = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
                pick = $urandom_range(0, 99);
                frame_len = (pick < 8) ? 32'd0 :
                            (pick < 97) ? $urandom_range(1, 24) : $urandom_range(200, 300);
                pick = $urandom_range(0, 99);
                sep_target = (pick < 70) ? 3 : $urandom_range(0, 6);
                body = new[frame_len];
                foreach (body[i])
                begin
                    pick = $urandom_range(0, 9);
                    b = (pick == 0) ? sf : (pick == 1) ? ss : 8'($urandom_range(0, 255));
                    body[i] = (b == sep) ? (b ^ 8'h01) : b;
                end
                if (frame_len != 0)
                begin
                    for (int k = 0; k < sep_target; k++)
                    begin
                        body[$urandom_range(0, frame_len - 1)] = sep;
                    end
                end
                push_item(sf);
                if (sf != ss && $urandom_range(0, 4) == 0)
                begin
                    push_item(sf);
                end
                push_item(ss);
                for (int i = 3; i >= 0; i--)
                begin
                    push_item(frame_type[8*i +: 8]);
                end
                for (int i = 3; i >= 0; i--)
                begin
                    push_item(frame_len[8*i +: 8]);
                end
                foreach (body[i])
                begin
                    push_item(body[i]);
                end
            end
            else if (pick < 87)
            begin
                push_item(sf);
                if (sf != ss && $urandom_range(0, 1) == 0)
                begin
                    push_item(sf);
                end
                b = 8'($urandom_range(0, 255));
                while (b == sf || b == ss)
                begin
                    b = 8'($urandom_range(0, 255));
                end
                push_item(b);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom_range(0, 255));
                    while (b == sf)
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    pending_bytes.push_back(b);
                end
            end
        end
    endfunction

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] sf, logic [7:0] ss, logic [7:0] sep);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= slfd_pkg::REG_SYNC_FIRST;
        cfg_data <= sf;
        @(posedge clk);
        cfg_index <= slfd_pkg::REG_SYNC_SECOND;
        cfg_data <= ss;
        @(posedge clk);
        cfg_index <= slfd_pkg::REG_FIELD_SEP;
        cfg_data <= sep;
        @(posedge clk);
        cfg_write <= 1'b0;
        model_cfg = '{sf, ss, sep};
    endtask

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    rx_byte <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    send_gap = sender_idles ? gap_len() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transfer: data_byte %0h", data_byte);
                    error_count++;
                end
                else
                begin
                    check_field("data_byte", 32'(expected_results[0].data_byte),
                                32'(data_byte));
                    check_field("data_valid", 32'(expected_results[0].data_valid),
                                32'(data_valid));
                    check_field("field_index", 32'(expected_results[0].field_index),
                                32'(field_index));
                    check_field("last_of_frame", 32'(expected_results[0].last_of_frame),
                                32'(last_of_frame));
                    check_field("msg_type", expected_results[0].msg_type, msg_type);
                    check_field("frame_status", 32'(expected_results[0].frame_status),
                                32'(frame_status));
                    void'(expected_results.pop_front());
                end
            end
            // one long hold-off so the input side backs up
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap = receiver_idles ? gap_len() : 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = OPENING_LEN - 1; i >= 0; i--)
        begin
            push_item(OPENING[8*i +: 8]);
        end
        fill_random(400);
        wait_drained();

        sender_idles = 1'b0;
        set_config(8'h00, 8'hFF, 8'h00);
        fill_random(400);
        wait_drained();

        sender_idles = 1'b1;
        receiver_idles = 1'b0;
        set_config(8'h55, 8'h55, 8'hFF);
        fill_random(400);
        wait_drained();

        receiver_idles = 1'b1;
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        fill_random(400);
        wait_drained();

        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
